>>> sv/image_rotation_address_mapper_top_defines.svh
// Assertion macros for the image rotation address mapper.
// Included by the RTL files that carry concurrent assertions; they need clk and rst_n in scope.
// The macros expand to nothing when SYNTH is defined.
`ifndef IMAGE_ROTATION_ADDRESS_MAPPER_TOP_DEFINES_SVH
`define IMAGE_ROTATION_ADDRESS_MAPPER_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked only while the block is out of reset.
`define IROT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("image rotation mapper assertion failed");
// Checked on every clock edge, reset included.
`define IROT_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("image rotation mapper reset assertion failed");
`else
`define IROT_ASSERT(lbl, prop)
`define IROT_ASSERT_NORST(lbl, prop)
`endif

`endif

>>> sv/irot_pkg.sv
// Shared types and constants for the image rotation address mapper.
// Used by irot_cfg, irot_map and image_rotation_address_mapper_top; no dependencies.
package irot_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned DEF_MAX_DIM        = 4096;
  localparam int unsigned DEF_COEF_FRAC_BITS = 14;

  // Field widths.
  localparam int unsigned SRC_DIM_W  = 13;
  localparam int unsigned DST_DIM_W  = 14;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned SRC_IDX_W  = 12;
  localparam int unsigned DST_IDX_W  = 13;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;

  // Reset values of the configuration registers.
  localparam logic [SRC_DIM_W-1:0]     RST_SRC_DIM = SRC_DIM_W'(1);
  localparam logic [DST_DIM_W-1:0]     RST_DST_DIM = DST_DIM_W'(1);
  localparam logic signed [COEF_W-1:0] RST_COS     = 16'sd16384;
  localparam logic signed [COEF_W-1:0] RST_SIN     = 16'sd0;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_COS_COEF   = 3'd4,
    REG_SIN_COEF   = 3'd5
  } irot_reg_t;

  // Saturated geometry and derived centers, handed from the register file to the datapath.
  typedef struct packed {
    logic [SRC_DIM_W-1:0]          w;
    logic [SRC_DIM_W-1:0]          h;
    logic [DST_DIM_W-1:0]          dw;
    logic [DST_DIM_W-1:0]          dh;
    logic signed [COEF_W-1:0]      cos_coef;
    logic signed [COEF_W-1:0]      sin_coef;
    logic [SRC_IDX_W-1:0]          x_base;  // w - 1 - source center, equals w/2
    logic [SRC_IDX_W-1:0]          y_base;  // h - 1 - source center, equals h/2
    logic signed [DST_DIM_W:0]     dcx;     // destination column center, -1 when dw is 0
    logic signed [DST_DIM_W:0]     dcy;     // destination row center, -1 when dh is 0
  } irot_cfg_t;

endpackage

>>> sv/irot_cfg.sv
// Configuration register file of the image rotation address mapper.
// Saturates the image sizes on write and derives the centers; depends on irot_pkg.
module irot_cfg import irot_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output irot_cfg_t             cfg
);

  logic [SRC_DIM_W-1:0]     w_r, h_r;
  logic [DST_DIM_W-1:0]     dw_r, dh_r;
  logic signed [COEF_W-1:0] cos_r, sin_r;
  logic [SRC_DIM_W-1:0]     src_sat;
  logic [DST_DIM_W-1:0]     dst_sat;
  logic [DST_DIM_W:0]       dw_inc, dh_inc;

  // Clamp written sizes to the supported maximum.
  always_comb begin
    src_sat = cfg_wdata[SRC_DIM_W-1:0];
    if ({1'b0, cfg_wdata[SRC_DIM_W-1:0]} > (SRC_DIM_W+1)'(MAX_DIM)) begin
      src_sat = SRC_DIM_W'(MAX_DIM);
    end
    dst_sat = cfg_wdata[DST_DIM_W-1:0];
    if ({1'b0, cfg_wdata[DST_DIM_W-1:0]} > (DST_DIM_W+1)'(2 * MAX_DIM)) begin
      dst_sat = DST_DIM_W'(2 * MAX_DIM);
    end
  end

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= RST_SRC_DIM;
      h_r   <= RST_SRC_DIM;
      dw_r  <= RST_DST_DIM;
      dh_r  <= RST_DST_DIM;
      cos_r <= RST_COS;
      sin_r <= RST_SIN;
    end else if (cfg_we) begin
      unique case (irot_reg_t'(cfg_addr))
        REG_SRC_WIDTH:  w_r   <= src_sat;
        REG_SRC_HEIGHT: h_r   <= src_sat;
        REG_DST_WIDTH:  dw_r  <= dst_sat;
        REG_DST_HEIGHT: dh_r  <= dst_sat;
        REG_COS_COEF:   cos_r <= $signed(cfg_wdata);
        REG_SIN_COEF:   sin_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Centers: (size + 1) / 2 - 1 for the destination, w - 1 - center reduces to w / 2.
  assign dw_inc = {1'b0, dw_r} + (DST_DIM_W+1)'(1);
  assign dh_inc = {1'b0, dh_r} + (DST_DIM_W+1)'(1);

  always_comb begin
    cfg.w        = w_r;
    cfg.h        = h_r;
    cfg.dw       = dw_r;
    cfg.dh       = dh_r;
    cfg.cos_coef = cos_r;
    cfg.sin_coef = sin_r;
    cfg.x_base   = w_r[SRC_DIM_W-1:1];
    cfg.y_base   = h_r[SRC_DIM_W-1:1];
    cfg.dcx      = $signed({1'b0, dw_inc[DST_DIM_W:1]}) - (DST_DIM_W+1)'(1);
    cfg.dcy      = $signed({1'b0, dh_inc[DST_DIM_W:1]}) - (DST_DIM_W+1)'(1);
  end

endmodule

>>> sv/irot_map.sv
// Coordinate datapath of the image rotation address mapper.
// Rotates one source coordinate into the destination and checks bounds; depends on irot_pkg.
module irot_map import irot_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  irot_cfg_t             cfg,
  input  logic [SRC_IDX_W-1:0]  src_row,
  input  logic [SRC_IDX_W-1:0]  src_col,
  output logic [DST_IDX_W-1:0]  dest_x,
  output logic [DST_IDX_W-1:0]  dest_y,
  output logic                  write_flag
);

  localparam int unsigned OFS_W  = SRC_IDX_W + 2;
  localparam int unsigned PROD_W = OFS_W + COEF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RND_W  = SUM_W + 1;
  localparam int unsigned POS_W  = RND_W + 2;

  logic signed [OFS_W-1:0]  x_ofs, y_ofs;
  logic signed [PROD_W-1:0] x_cos, y_sin, x_sin, y_cos;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [RND_W-1:0]  rx, ry;
  logic signed [POS_W-1:0]  xf, yf;
  logic                     src_in, dst_in;

  // Round a fixed-point sum to an integer, half away from zero.
  function automatic logic signed [RND_W-1:0] round_q(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] mag;
    logic [RND_W-1:0] q;
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    q   = ({1'b0, mag} + (RND_W'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    return s[SUM_W-1] ? -$signed(q) : $signed(q);
  endfunction

  // Offsets from the source center, flipped in both axes.
  assign x_ofs = $signed(OFS_W'(cfg.x_base)) - $signed(OFS_W'(src_col));
  assign y_ofs = $signed(OFS_W'(cfg.y_base)) - $signed(OFS_W'(src_row));

  // Four parallel multiplies of the rotation matrix.
  assign x_cos = PROD_W'(x_ofs * cfg.cos_coef);
  assign y_sin = PROD_W'(y_ofs * cfg.sin_coef);
  assign x_sin = PROD_W'(x_ofs * cfg.sin_coef);
  assign y_cos = PROD_W'(y_ofs * cfg.cos_coef);

  assign sum_x = SUM_W'(x_cos) + SUM_W'(y_sin);
  assign sum_y = SUM_W'(y_cos) - SUM_W'(x_sin);
  assign rx    = round_q(sum_x);
  assign ry    = round_q(sum_y);

  // Destination coordinate measured back from the destination center.
  assign xf = POS_W'(cfg.dcx) - POS_W'(rx);
  assign yf = POS_W'(cfg.dcy) - POS_W'(ry);

  // Bounds checks on both images.
  assign src_in = ({1'b0, src_row} < cfg.h) && ({1'b0, src_col} < cfg.w);
  assign dst_in = !xf[POS_W-1] && (xf[POS_W-2:0] < (POS_W-1)'(cfg.dw)) &&
                  !yf[POS_W-1] && (yf[POS_W-2:0] < (POS_W-1)'(cfg.dh));

  assign write_flag = src_in && dst_in;
  assign dest_x     = write_flag ? xf[DST_IDX_W-1:0] : '0;
  assign dest_y     = write_flag ? yf[DST_IDX_W-1:0] : '0;

endmodule

>>> sv/image_rotation_address_mapper_top.sv
// Top level of the image rotation address mapper: stream ports, input and result registers.
// Depends on irot_pkg, irot_cfg, irot_map and image_rotation_address_mapper_top_defines.svh.
//
// Usage: source pixels enter on the in_ stream, one request per pixel with its row and
// column. Each request yields exactly one result on the out_ stream holding the destination
// column and row, the unchanged pixel and, in out_tuser, a write flag that is set when the
// point falls inside both the source and destination images (coordinates read 0 otherwise).
// Sizes and Q1.14 cosine/sine are written on the cfg_ port; the user must write them only while
// no request is in flight, as the block itself does not enforce this. Each accepted request
// waits in the input register while the rotation datapath (four parallel multiplies, add, round,
// bound compare) works on it, and then moves to the result register, which drives out_tvalid.
// Without a receiver stall the block takes one request per clock. When the receiver stalls, the
// result register holds its request and the input register still takes one more, after which
// in_tready drops until the result is taken.
// Synchronous active-low reset empties both registers and loads the default configuration:
// all sizes 1, cosine 1.0 and sine 0.
`include "image_rotation_address_mapper_top_defines.svh"

module image_rotation_address_mapper_top import irot_pkg::*; #(
  parameter int unsigned MAX_DIM        = DEF_MAX_DIM,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Source pixel stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // src_row[11:0], src_col[23:12], pixel_in[55:24]
  // Mapped pixel stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // dest_x[12:0], dest_y[25:13], pixel_out[57:26]
  output logic                  out_tuser   // write_flag
);

  irot_cfg_t             cfg;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [SRC_IDX_W-1:0]  s1_row_r, s1_col_r;
  logic [PIX_W-1:0]      s1_pix_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [DST_IDX_W-1:0]  out_x_r, out_y_r;
  logic [PIX_W-1:0]      out_pix_r;
  logic                  out_flag_r;
  logic [DST_IDX_W-1:0]  map_x, map_y;
  logic                  map_flag;
  logic                  out_free, s1_move, in_take;

  irot_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  irot_map #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_map (
    .cfg        (cfg),
    .src_row    (s1_row_r),
    .src_col    (s1_col_r),
    .dest_x     (map_x),
    .dest_y     (map_y),
    .write_flag (map_flag)
  );

  // Handshake: each register advances when the one after it is empty or draining.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_tready);

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_row_r <= in_tdata[SRC_IDX_W-1:0];
      s1_col_r <= in_tdata[2*SRC_IDX_W-1:SRC_IDX_W];
      s1_pix_r <= in_tdata[2*SRC_IDX_W+PIX_W-1:2*SRC_IDX_W];
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_x_r    <= map_x;
      out_y_r    <= map_y;
      out_pix_r  <= s1_pix_r;
      out_flag_r <= map_flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-2*DST_IDX_W-PIX_W)'(0), out_pix_r, out_y_r, out_x_r};
  assign out_tuser  = out_flag_r;

  // A dropped point carries zero coordinates.
  `IROT_ASSERT(a_drop_zero, out_tvalid && !out_tuser |-> out_tdata[2*DST_IDX_W-1:0] == '0)
  // A written point lies inside the destination width.
  `IROT_ASSERT(a_x_inside, out_tvalid && out_tuser |-> {1'b0, out_tdata[DST_IDX_W-1:0]} < cfg.dw)
  // An accepted request always lands in the input register.
  `IROT_ASSERT(a_in_to_s1, in_tvalid && in_tready |=> s1_valid_r)
  // The pixel moves unchanged from the input register to the result.
  `IROT_ASSERT(a_pix_pass, s1_move |=> out_pix_r == $past(s1_pix_r))
  // Reset empties both registers.
  `IROT_ASSERT_NORST(a_reset_idle, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule
